>>> hdl/wsbd_pkg.sv
package wsbd_pkg;

  // Field widths of one tick and one result
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SPEED_W = 14;
  localparam int unsigned PRESS_W = 16;
  localparam int unsigned WIN_W   = 16;

  // Stream payload widths, rounded up to whole bytes
  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 40;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SWING    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SWING = 2'd2;

  localparam logic [WIN_W-1:0]   WINDOW_RESET      = 16'd1200;
  localparam logic [SPEED_W-1:0] SPEED_SWING_RESET = 14'd300;
  localparam logic [PRESS_W-1:0] PRESS_SWING_RESET = 16'd100;

  // One stored sample pair, as held in each cell of the chain
  typedef struct packed {
    logic               valid;
    logic [TIME_W-1:0]  speed_stamp;
    logic [SPEED_W-1:0] speed_value;
    logic [TIME_W-1:0]  pressure_stamp;
    logic [PRESS_W-1:0] pressure_value;
  } entry_t;

endpackage

>>> hdl/windowed_swing_blip_detector_unit.sv
// Windowed swing blip detector.
// Input stream (s_*): one transaction per tick carrying the time now and the
// latest speed and pressure samples with their timestamps; s_tuser is the
// restart flag. Output stream (m_*): one result transaction per tick with
// the sticky blip flag and the peak-to-peak swing of each signal over the
// samples whose age is within the age limit register.
// A tick with both timestamps nonzero is pushed into a chain of RING_DEPTH
// cells; the chain then rotates once round while the tail cell feeds two
// min/max trackers. Each tick therefore occupies the block until that one
// rotation ends; a tick that pushes nothing skips it. The result is loaded
// into the output register in the finish state that follows the rotation.
// The result sits in an output register; the next tick is taken while it
// waits. If the receiver stalls, the following tick finishes its scan and
// then waits until the register frees, holding s_tready low meanwhile.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and
// are to be made while the block is idle.
// Reset empties the chain, clears the blip flag and reloads the registers
// with window 1200 ms, speed swing 300 rpm and pressure swing 1.00 kPa.
module windowed_swing_blip_detector_unit #(
  parameter int unsigned RING_DEPTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // s_tdata fields, low bit up: now_ms, speed_time_ms, engine_speed,
  // pressure_time_ms, pressure, zero fill
  input  logic [wsbd_pkg::IN_DATA_W-1:0]       s_tdata,
  // s_tuser fields: restart
  input  logic                                 s_tuser,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // m_tdata fields, low bit up: blip, speed_swing, speed_seen,
  // pressure_swing, pressure_seen, zero fill
  output logic [wsbd_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 cfg_we,
  input  logic [wsbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsbd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned CNT_W = $clog2(RING_DEPTH);
  localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(RING_DEPTH - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SHIFT  = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [CNT_W-1:0] scan_count;

  logic [wsbd_pkg::WIN_W-1:0]   age_limit;
  logic [wsbd_pkg::SPEED_W-1:0] speed_swing_min;
  logic [wsbd_pkg::PRESS_W-1:0] pressure_swing_min;

  logic                          item_restart;
  logic [wsbd_pkg::TIME_W-1:0]   item_now;
  logic [wsbd_pkg::TIME_W-1:0]   item_speed_time;
  logic [wsbd_pkg::SPEED_W-1:0]  item_speed;
  logic [wsbd_pkg::TIME_W-1:0]   item_pressure_time;
  logic [wsbd_pkg::PRESS_W-1:0]  item_pressure;
  logic                          item_push;

  logic blip;
  logic blip_next;

  wsbd_pkg::entry_t cell_d [RING_DEPTH];
  wsbd_pkg::entry_t cell_q [RING_DEPTH];
  wsbd_pkg::entry_t new_entry;
  wsbd_pkg::entry_t tail;

  logic chain_shift;
  logic chain_clear;
  logic span_start;
  logic span_en;

  logic [wsbd_pkg::TIME_W-1:0]  speed_age;
  logic [wsbd_pkg::TIME_W-1:0]  pressure_age;
  logic                         speed_hit;
  logic                         pressure_hit;
  logic                         speed_seen;
  logic                         pressure_seen;
  logic [wsbd_pkg::SPEED_W-1:0] speed_swing;
  logic [wsbd_pkg::PRESS_W-1:0] pressure_swing;

  logic in_take;
  logic out_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit          <= wsbd_pkg::WINDOW_RESET;
      speed_swing_min    <= wsbd_pkg::SPEED_SWING_RESET;
      pressure_swing_min <= wsbd_pkg::PRESS_SWING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wsbd_pkg::REG_AGE_LIMIT:      age_limit <= cfg_data;
        wsbd_pkg::REG_SPEED_SWING:    speed_swing_min <= cfg_data[wsbd_pkg::SPEED_W-1:0];
        wsbd_pkg::REG_PRESSURE_SWING: pressure_swing_min <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign in_take  = s_tvalid && s_tready;

  // Latch the tick for the length of its processing
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_restart       <= s_tuser;
      item_now           <= s_tdata[31:0];
      item_speed_time    <= s_tdata[63:32];
      item_speed         <= s_tdata[77:64];
      item_pressure_time <= s_tdata[109:78];
      item_pressure      <= s_tdata[125:110];
    end
  end

  assign item_push = (item_speed_time != '0) && (item_pressure_time != '0);

  // Sequencer: push or clear, rotate the chain once, then deliver
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_take) state_next = ST_SHIFT;
      ST_SHIFT:  state_next = item_push ? ST_SCAN : ST_FINISH;
      ST_SCAN:   if (scan_count == LAST_CELL) state_next = ST_FINISH;
      ST_FINISH: if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state != ST_SCAN) begin
      scan_count <= '0;
    end else begin
      scan_count <= scan_count + CNT_W'(1);
    end
  end

  // Chain control
  assign chain_clear = (state == ST_SHIFT) && item_restart;
  assign chain_shift = ((state == ST_SHIFT) && item_push) || (state == ST_SCAN);
  assign span_start  = (state == ST_SHIFT);
  assign span_en     = (state == ST_SCAN);

  always_comb begin
    new_entry.valid          = 1'b1;
    new_entry.speed_stamp    = item_speed_time;
    new_entry.speed_value    = item_speed;
    new_entry.pressure_stamp = item_pressure_time;
    new_entry.pressure_value = item_pressure;
  end

  assign tail = cell_q[RING_DEPTH-1];

  // Head takes the new sample on a push and the tail while rotating; a
  // restart drops every older entry, as the push goes in if there is one.
  always_comb begin
    cell_d[0] = (state == ST_SHIFT) ? new_entry : tail;
    for (int i = 1; i < RING_DEPTH; i++) begin
      cell_d[i]       = cell_q[i-1];
      cell_d[i].valid = cell_q[i-1].valid && !chain_clear;
    end
  end

  for (genvar g = 0; g < RING_DEPTH; g++) begin : g_cell
    wsbd_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (chain_shift),
      .clear (chain_clear),
      .d     (cell_d[g]),
      .q     (cell_q[g])
    );
  end

  // Window test on the tail entry
  assign speed_age    = item_now - tail.speed_stamp;
  assign pressure_age = item_now - tail.pressure_stamp;
  assign speed_hit    = tail.valid &&
                        (speed_age <= {{(wsbd_pkg::TIME_W - wsbd_pkg::WIN_W){1'b0}}, age_limit});
  assign pressure_hit = tail.valid &&
                        (pressure_age <= {{(wsbd_pkg::TIME_W - wsbd_pkg::WIN_W){1'b0}}, age_limit});

  wsbd_span #(
    .WIDTH (wsbd_pkg::SPEED_W)
  ) u_speed_span (
    .clk   (clk),
    .rst   (rst),
    .start (span_start),
    .en    (span_en),
    .hit   (speed_hit),
    .value (tail.speed_value),
    .seen  (speed_seen),
    .swing (speed_swing)
  );

  wsbd_span #(
    .WIDTH (wsbd_pkg::PRESS_W)
  ) u_pressure_span (
    .clk   (clk),
    .rst   (rst),
    .start (span_start),
    .en    (span_en),
    .hit   (pressure_hit),
    .value (tail.pressure_value),
    .seen  (pressure_seen),
    .swing (pressure_swing)
  );

  // Sticky flag update at the end of the tick
  assign out_load = (state == ST_FINISH) && (!m_tvalid || m_tready);

  always_comb begin
    blip_next = item_restart ? 1'b0 : blip;
    if (item_push && speed_seen && pressure_seen &&
        speed_swing >= speed_swing_min && pressure_swing >= pressure_swing_min) begin
      blip_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blip <= 1'b0;
    end else if (out_load) begin
      blip <= blip_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, pressure_seen, pressure_swing, speed_seen, speed_swing, blip_next};
    end
  end

endmodule

>>> hdl/wsbd_cell.sv
// One storage cell of the sample chain. It takes its neighbour's entry
// whenever the chain moves, and can drop its entry on a restart.
module wsbd_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic              clear,
  input  wsbd_pkg::entry_t  d,
  output wsbd_pkg::entry_t  q
);

  // Valid bit is cleared by reset or restart, otherwise it follows the chain.
  // The sample payload moves with the chain and needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (shift) begin
      q.valid <= d.valid;
    end else if (clear) begin
      q.valid <= 1'b0;
    end
    if (shift) begin
      q.speed_stamp    <= d.speed_stamp;
      q.speed_value    <= d.speed_value;
      q.pressure_stamp <= d.pressure_stamp;
      q.pressure_value <= d.pressure_value;
    end
  end

endmodule

>>> hdl/wsbd_span.sv
// Running minimum and maximum of the samples that fall inside the window,
// fed one entry per cycle from the tail of the chain.
module wsbd_span #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             en,
  input  logic             hit,
  input  logic [WIDTH-1:0] value,
  output logic             seen,
  output logic [WIDTH-1:0] swing
);

  logic [WIDTH-1:0] lo;
  logic [WIDTH-1:0] hi;

  // Seen flag
  always_ff @(posedge clk) begin
    if (rst || start) begin
      seen <= 1'b0;
    end else if (en && hit) begin
      seen <= 1'b1;
    end
  end

  // Extremes; the first hit loads both
  always_ff @(posedge clk) begin
    if (start) begin
      lo <= '0;
      hi <= '0;
    end else if (en && hit) begin
      if (!seen || value < lo) begin
        lo <= value;
      end
      if (!seen || value > hi) begin
        hi <= value;
      end
    end
  end

  assign swing = hi - lo;

endmodule

>>> hdl/wsbd_checker.sv
// Port-level checks for the blip detector.
module wsbd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [wsbd_pkg::OUT_DATA_W-1:0] m_tdata
);

  // No result is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid straight after reset");

  // A stalled result holds its data.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Ticks are taken one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second tick taken while one is in progress");

  // An empty speed window reports no swing.
  a_speed_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[15] |-> m_tdata[14:1] == '0)
    else $error("speed swing without any sample in window");

  // An empty pressure window reports no swing.
  a_pressure_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[32] |-> m_tdata[31:16] == '0)
    else $error("pressure swing without any sample in window");

endmodule

bind windowed_swing_blip_detector_unit wsbd_checker u_wsbd_checker (.*);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RING_DEPTH = 24;
  // Longest stretch without any transaction before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 3000;
  // Receiver hold-off that backs the block up into its input.
  localparam int unsigned HOLD_AT  = 60;
  localparam int unsigned HOLD_LEN = 400;

  typedef struct packed {
    logic                         restart;
    logic [wsbd_pkg::TIME_W-1:0]  now;
    logic [wsbd_pkg::TIME_W-1:0]  speed_time;
    logic [wsbd_pkg::SPEED_W-1:0] speed;
    logic [wsbd_pkg::TIME_W-1:0]  press_time;
    logic [wsbd_pkg::PRESS_W-1:0] press;
  } tick_t;

  typedef struct packed {
    logic                         blip;
    logic [wsbd_pkg::SPEED_W-1:0] speed_swing;
    logic                         speed_seen;
    logic [wsbd_pkg::PRESS_W-1:0] press_swing;
    logic                         press_seen;
  } swing_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic [wsbd_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                            s_tuser = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [wsbd_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [wsbd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wsbd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  windowed_swing_blip_detector_unit #(
    .RING_DEPTH(RING_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Mirror of the register file and of the sample history.
  logic [wsbd_pkg::WIN_W-1:0]   window_lim = wsbd_pkg::WINDOW_RESET;
  logic [wsbd_pkg::SPEED_W-1:0] speed_min  = wsbd_pkg::SPEED_SWING_RESET;
  logic [wsbd_pkg::PRESS_W-1:0] press_min  = wsbd_pkg::PRESS_SWING_RESET;
  logic [wsbd_pkg::TIME_W-1:0]  hist_speed_stamp [RING_DEPTH];
  logic [wsbd_pkg::SPEED_W-1:0] hist_speed       [RING_DEPTH];
  logic [wsbd_pkg::TIME_W-1:0]  hist_press_stamp [RING_DEPTH];
  logic [wsbd_pkg::PRESS_W-1:0] hist_press       [RING_DEPTH];
  int unsigned        hist_wr = 0;
  int unsigned        hist_fill = 0;
  logic               blip_state = 1'b0;

  tick_t       pending_ticks[$];
  swing_t      predicted_swings[$];
  tick_t       cur_tick;
  logic        calm = 1'b0;
  logic [31:0] sim_now = 32'd1000;
  int unsigned speed_level = 3000;
  int unsigned press_level = 9000;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned results_taken = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ticks_sent = 0;
  int unsigned restarts_sent = 0;
  int unsigned results_seen = 0;
  int unsigned blips_seen = 0;
  int unsigned errors = 0;

  // Pushes a tick into the history and works out the swings it reports.
  function automatic swing_t advance_detector(input tick_t t);
    swing_t                       r;
    logic [wsbd_pkg::TIME_W-1:0]  age;
    logic [wsbd_pkg::SPEED_W-1:0] s_lo, s_hi;
    logic [wsbd_pkg::PRESS_W-1:0] p_lo, p_hi;
    r = '0;
    if (t.restart) begin
      hist_wr = 0;
      hist_fill = 0;
      blip_state = 1'b0;
    end
    if (t.speed_time != '0 && t.press_time != '0) begin
      hist_speed_stamp[hist_wr] = t.speed_time;
      hist_speed[hist_wr] = t.speed;
      hist_press_stamp[hist_wr] = t.press_time;
      hist_press[hist_wr] = t.press;
      hist_wr = (hist_wr == RING_DEPTH - 1) ? 0 : hist_wr + 1;
      if (hist_fill < RING_DEPTH) hist_fill++;
      s_lo = '0;
      s_hi = '0;
      p_lo = '0;
      p_hi = '0;
      for (int unsigned i = 0; i < hist_fill; i++) begin
        age = t.now - hist_speed_stamp[i];
        if (age <= {16'd0, window_lim}) begin
          if (!r.speed_seen || hist_speed[i] < s_lo) s_lo = hist_speed[i];
          if (!r.speed_seen || hist_speed[i] > s_hi) s_hi = hist_speed[i];
          r.speed_seen = 1'b1;
        end
        age = t.now - hist_press_stamp[i];
        if (age <= {16'd0, window_lim}) begin
          if (!r.press_seen || hist_press[i] < p_lo) p_lo = hist_press[i];
          if (!r.press_seen || hist_press[i] > p_hi) p_hi = hist_press[i];
          r.press_seen = 1'b1;
        end
      end
      r.speed_swing = s_hi - s_lo;
      r.press_swing = p_hi - p_lo;
      if (r.speed_seen && r.press_seen && r.speed_swing >= speed_min &&
          r.press_swing >= press_min)
        blip_state = 1'b1;
    end
    r.blip = blip_state;
    return r;
  endfunction

  // Idle length for either side: mostly short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Sample timestamp: mostly inside or just around the window, sometimes absent,
  // in the future or anywhere at all.
  function automatic logic [31:0] pick_stamp(input logic [31:0] now,
                                             input logic [31:0] win);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return 32'd0;
    if (r < 8) return now + $urandom_range(1, 2000);
    if (r < 11) return $urandom();
    if (r < 21) return now - win;
    if (r < 25) return now - win - 1;
    return now - $urandom_range(0, win + win / 2 + 2);
  endfunction

  // Signal level: a random walk round the last value, with jumps and extremes.
  function automatic int unsigned pick_level(input int unsigned centre,
                                             input int unsigned top,
                                             input int unsigned spread);
    int          v;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return ($urandom_range(0, 1) != 0) ? top : 0;
    if (r < 4) return $urandom_range(0, top);
    v = int'(centre) + int'($urandom_range(0, 2 * spread)) - int'(spread);
    if (v < 0) v = 0;
    if (v > int'(top)) v = int'(top);
    return v;
  endfunction

  function automatic tick_t mk_tick(input logic restart, input logic [31:0] now,
                                    input logic [31:0] st, input int unsigned sp,
                                    input logic [31:0] pt, input int unsigned pr);
    tick_t t;
    t.restart = restart;
    t.now = now;
    t.speed_time = st;
    t.speed = sp[wsbd_pkg::SPEED_W-1:0];
    t.press_time = pt;
    t.press = pr[wsbd_pkg::PRESS_W-1:0];
    return t;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic write_reg(input logic [wsbd_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[wsbd_pkg::CFG_DATA_W-1:0];
    case (idx)
      wsbd_pkg::REG_AGE_LIMIT: begin
        window_lim = value[wsbd_pkg::WIN_W-1:0];
      end
      wsbd_pkg::REG_SPEED_SWING: begin
        speed_min = value[wsbd_pkg::SPEED_W-1:0];
      end
      wsbd_pkg::REG_PRESSURE_SWING: begin
        press_min = value[wsbd_pkg::PRESS_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  // Waits until every tick has gone in and every result has come out.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || s_tvalid || predicted_swings.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned win, input int unsigned spd,
                           input int unsigned prs, input int unsigned count,
                           input logic quiet);
    tick_t       t;
    int unsigned r;
    wait_idle();
    write_reg(wsbd_pkg::REG_AGE_LIMIT, win);
    write_reg(wsbd_pkg::REG_SPEED_SWING, spd);
    write_reg(wsbd_pkg::REG_PRESSURE_SWING, prs);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    calm = quiet;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) sim_now = $urandom();
      else if (r < 5) sim_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      else sim_now = sim_now + $urandom_range(0, window_lim / 6 + 2);
      speed_level = pick_level(speed_level, 16383, 250);
      press_level = pick_level(press_level, 65535, 120);
      t.restart = ($urandom_range(0, 99) < 4);
      t.now = sim_now;
      t.speed_time = pick_stamp(sim_now, {16'd0, window_lim});
      t.speed = speed_level[wsbd_pkg::SPEED_W-1:0];
      t.press_time = pick_stamp(sim_now, {16'd0, window_lim});
      t.press = press_level[wsbd_pkg::PRESS_W-1:0];
      pending_ticks.push_back(t);
    end
  endtask

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Sender: one tick per transaction, with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predicted_swings.push_back(advance_detector(cur_tick));
        ticks_sent++;
        if (cur_tick.restart) restarts_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          s_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_ticks.size() != 0) begin
          cur_tick = pending_ticks.pop_front();
          s_tdata <= {{(wsbd_pkg::IN_DATA_W - 126){1'b0}}, cur_tick.press,
                      cur_tick.press_time, cur_tick.speed, cur_tick.speed_time,
                      cur_tick.now};
          s_tuser <= cur_tick.restart;
          s_tvalid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) results_taken <= results_taken + 1;
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_taken == HOLD_AT) begin
        m_tready <= 1'b0;
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
      end else if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
    end
  end

  // Result checker: each result transaction against the oldest prediction.
  always @(posedge clk) begin
    swing_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.blip = m_tdata[0];
      got.speed_swing = m_tdata[14:1];
      got.speed_seen = m_tdata[15];
      got.press_swing = m_tdata[31:16];
      got.press_seen = m_tdata[32];
      results_seen++;
      if (got.blip) blips_seen++;
      if (predicted_swings.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, got);
        errors++;
      end else begin
        want = predicted_swings.pop_front();
        check_field("blip", 32'(want.blip), 32'(got.blip));
        check_field("speed_swing", 32'(want.speed_swing), 32'(got.speed_swing));
        check_field("speed_seen", 32'(want.speed_seen), 32'(got.speed_seen));
        check_field("pressure_swing", 32'(want.press_swing), 32'(got.press_swing));
        check_field("pressure_seen", 32'(want.press_seen), 32'(got.press_seen));
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("windowed_swing_blip_detector_unit: mismatch");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed ticks under the reset register values.
    // Restart together with a missing speed sample, then a missing pressure one.
    pending_ticks.push_back(mk_tick(1'b1, 1000, 0, 5, 1000, 5));
    pending_ticks.push_back(mk_tick(1'b0, 1000, 1000, 5, 0, 5));
    // Lowest values, then highest, which sets the flag.
    pending_ticks.push_back(mk_tick(1'b0, 1000, 1000, 0, 1000, 0));
    pending_ticks.push_back(mk_tick(1'b0, 1500, 1400, 16383, 1450, 65535));
    // Both samples absent: the flag holds and the swings read zero.
    pending_ticks.push_back(mk_tick(1'b0, 1600, 0, 0, 0, 0));
    // Restart with a push, then entries exactly at and just past the window edge.
    pending_ticks.push_back(mk_tick(1'b1, 5000, 4990, 100, 4995, 200));
    pending_ticks.push_back(mk_tick(1'b0, 6300, 6300, 400, 6300, 250));
    pending_ticks.push_back(mk_tick(1'b0, 7500, 7500, 500, 7500, 260));
    pending_ticks.push_back(mk_tick(1'b0, 7501, 7501, 450, 7501, 255));
    // Speed stamp in the future.
    pending_ticks.push_back(mk_tick(1'b0, 8000, 8100, 9000, 8000, 300));
    // Ages across the 32-bit wrap, then swings exactly on both thresholds.
    pending_ticks.push_back(mk_tick(1'b1, 32'h0000_0100, 32'hFFFF_FF80, 1000,
                                    32'hFFFF_FF00, 2000));
    pending_ticks.push_back(mk_tick(1'b0, 32'h0000_0180, 32'h0000_0180, 1300,
                                    32'h0000_0100, 2100));
    // Swings one short of each threshold, then speed on its threshold with pressure still one short.
    pending_ticks.push_back(mk_tick(1'b1, 20000, 20000, 1000, 20000, 2000));
    pending_ticks.push_back(mk_tick(1'b0, 20010, 20010, 1299, 20010, 2099));
    pending_ticks.push_back(mk_tick(1'b0, 20020, 20020, 1300, 20020, 2050));
    // All-ones time, then time zero with a pressure stamp just ahead of it.
    pending_ticks.push_back(mk_tick(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16383,
                                    32'hFFFF_FFFE, 65535));
    pending_ticks.push_back(mk_tick(1'b1, 0, 32'hFFFF_FC00, 7, 1, 9));

    // Random phases over a spread of register settings.
    run_phase(1200, 300, 100, 130, 1'b0);
    run_phase(0, 0, 0, 110, 1'b1);
    run_phase(65535, 16383, 65535, 110, 1'b0);
    run_phase(1, 1, 1, 100, 1'b1);
    run_phase($urandom_range(50, 5000), $urandom_range(0, 2000),
              $urandom_range(0, 3000), 100, 1'b0);
    run_phase(1200, 300, 100, 100, 1'b0);

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Sent %0d ticks (%0d with restart) and checked %0d results, %0d with blip set,",
             ticks_sent, restarts_sent, results_seen, blips_seen);
    $display("across six register settings including window zero and all-ones limits.");
    if (errors == 0) begin
      $display("windowed_swing_blip_detector_unit: match");
    end else begin
      $display("windowed_swing_blip_detector_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/wsbd_pkg.sv
hdl/wsbd_cell.sv
hdl/wsbd_span.sv
hdl/windowed_swing_blip_detector_unit.sv
hdl/wsbd_checker.sv
verif/tb.sv
